/* design/bicubic_grid_interpolator_macros.svh */
// assertion macros for the bicubic grid interpolator
// used by the modules that carry concurrent checks; no other dependencies
`ifndef BICUBIC_GRID_INTERPOLATOR_MACROS_SVH
`define BICUBIC_GRID_INTERPOLATOR_MACROS_SVH
`ifndef SYNTH
`define BGI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BGI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BGI_ASSERT(label, prop, msg)
`define BGI_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* design/bgi_pkg.sv */
// shared constants, codes and controller/datapath structs of the interpolator
// no dependencies
package bgi_pkg;
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int FRAC_BITS   = 16;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CNT_W       = 7;
  localparam int DATA_W      = 32;
  localparam int VAL_W       = 48;
  localparam int TC_W        = FRAC_BITS + 1;
  localparam int NUM_W       = DATA_W + 1 + FRAC_BITS;
  localparam int DEN_W       = DATA_W + 1;
  localparam int PROD_W      = VAL_W + TC_W + 1;
  localparam int GRID_AW     = COL_W + ROW_W;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_X    = 2'd0,
    OP_LOAD_Y    = 2'd1,
    OP_LOAD_GRID = 2'd2,
    OP_QUERY     = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_ACCEPT, DP_SRCH, DP_RK0, DP_RK1, DP_DIV_GO, DP_TSET, DP_GRD,
    DP_CABC, DP_CM1, DP_CS, DP_CM2, DP_CR, DP_CM3, DP_CF, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   axis;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic div_busy;
    logic gj_last;
    logic row_last;
    logic out_free;
  } dp_sts_t;
endpackage

/* design/bgi_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// depends on bgi_pkg
module bgi_div import bgi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    rem_sh   = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule

/* design/bgi_dp.sv */
// datapath: knot and grid memories, interval search, normalization, cubic unit
// depends on bgi_pkg and bgi_div
module bgi_dp import bgi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  opcode_t                  opcode,
  input  logic [COL_W-1:0]         column_index,
  input  logic [ROW_W-1:0]         row_index,
  input  logic signed [DATA_W-1:0] load_value,
  input  logic signed [DATA_W-1:0] query_x,
  input  logic signed [DATA_W-1:0] query_y,
  input  logic [CNT_W-1:0]         n_cols,
  input  logic [CNT_W-1:0]         n_rows,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_sat
);
  localparam logic [TC_W-1:0] ONE = TC_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF17 = PROD_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] SAT_HI =
    $signed({{(VAL_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
  localparam logic signed [VAL_W-1:0] SAT_LO =
    $signed({{(VAL_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});

  logic [DATA_W-1:0] xmem [MAX_COLUMNS];
  logic [DATA_W-1:0] ymem [MAX_ROWS];
  logic [DATA_W-1:0] gmem [MAX_ROWS*MAX_COLUMNS];
  logic [DATA_W-1:0] xrd_r, yrd_r, grd_r;

  logic signed [DATA_W-1:0] qx_r, qy_r, k0_r;
  logic [COL_W-1:0] xi_r;
  logic [ROW_W-1:0] yi_r;
  logic [CNT_W-1:0] k_r, pk_r;
  logic             pend_r, gpend_r;
  logic [1:0]       gi_r, gj_r, pj_r;
  logic [TC_W-1:0]  t_r, u_r;
  logic             num_neg_r, den_neg_r, den_zero_r;
  logic signed [VAL_W-1:0]  p_r [4];
  logic signed [VAL_W-1:0]  buf_r [4];
  logic signed [VAL_W-1:0]  a_r, b_r, c_r, acc_r;
  logic signed [PROD_W-1:0] m_r;
  logic signed [DATA_W-1:0] res_r;
  logic                     rsat_r;
  logic                     ov_r;
  logic signed [DATA_W-1:0] ovl_r;
  logic                     osat_r;

  logic acc_in;
  logic [CNT_W-1:0] lim;
  logic issue;
  logic signed [DATA_W-1:0] q_sel, kd;
  logic [COL_W-1:0] xa;
  logic [ROW_W-1:0] ya;
  logic [CNT_W:0]   rv, cv;
  logic [ROW_W-1:0] gr;
  logic [COL_W-1:0] gc;
  logic signed [DATA_W:0] dq, dk;
  logic signed [NUM_W-1:0] num_s;
  logic [NUM_W-1:0] num_mag, quot;
  logic [DEN_W-1:0] den_mag;
  logic div_busy;
  logic [TC_W-1:0] tq, tc;
  logic signed [VAL_W-1:0] pv [4];
  logic signed [VAL_W-1:0] mop, fin;
  logic signed [PROD_W-1:0] mop_x, tc_x, prod, r16, r17;

  assign acc_in = (cmd.op == DP_ACCEPT);
  assign lim    = (cmd.axis ? n_rows : n_cols) - CNT_W'(2);
  assign issue  = (cmd.op == DP_SRCH) && (k_r <= lim);
  assign q_sel  = cmd.axis ? qy_r : qx_r;
  assign kd     = cmd.axis ? $signed(yrd_r) : $signed(xrd_r);

  always_comb begin
    xa = COL_W'(k_r);
    ya = ROW_W'(k_r);
    case (cmd.op)
      DP_SRCH: begin
        xa = COL_W'(k_r);
        ya = ROW_W'(k_r);
      end
      DP_RK0: begin
        xa = xi_r;
        ya = yi_r;
      end
      default: begin
        xa = xi_r + COL_W'(1);
        ya = yi_r + ROW_W'(1);
      end
    endcase
  end

  // neighborhood indices clamped to the rows and columns in use
  always_comb begin
    rv = {2'b00, yi_r} + {{(CNT_W-1){1'b0}}, gi_r} - (CNT_W+1)'(1);
    cv = {2'b00, xi_r} + {{(CNT_W-1){1'b0}}, gj_r} - (CNT_W+1)'(1);
    if (rv[CNT_W]) gr = '0;
    else if (rv[CNT_W-1:0] >= n_rows) gr = ROW_W'(n_rows - CNT_W'(1));
    else gr = rv[ROW_W-1:0];
    if (cv[CNT_W]) gc = '0;
    else if (cv[CNT_W-1:0] >= n_cols) gc = COL_W'(n_cols - CNT_W'(1));
    else gc = cv[COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (acc_in && opcode == OP_LOAD_X) xmem[column_index] <= load_value;
    xrd_r <= xmem[xa];
  end

  always_ff @(posedge clk) begin
    if (acc_in && opcode == OP_LOAD_Y) ymem[row_index] <= load_value;
    yrd_r <= ymem[ya];
  end

  always_ff @(posedge clk) begin
    if (acc_in && opcode == OP_LOAD_GRID) gmem[{row_index, column_index}] <= load_value;
    grd_r <= gmem[{gr, gc}];
  end

  // normalization operands: (q - k0) << frac over (k1 - k0), magnitudes only
  always_comb begin
    dq      = $signed({q_sel[DATA_W-1], q_sel}) - $signed({k0_r[DATA_W-1], k0_r});
    dk      = $signed({kd[DATA_W-1], kd}) - $signed({k0_r[DATA_W-1], k0_r});
    num_s   = $signed({dq, {FRAC_BITS{1'b0}}});
    num_mag = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    den_mag = dk[DATA_W] ? DEN_W'(-dk) : DEN_W'(dk);
  end

  bgi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == DP_DIV_GO),
    .num   (num_mag),
    .den   (den_mag),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_comb begin
    if (den_zero_r || (num_neg_r != den_neg_r)) tq = '0;
    else if (quot > NUM_W'(ONE)) tq = ONE;
    else tq = quot[TC_W-1:0];
  end

  // cubic unit: one shared multiplier, t or u times a running term
  always_comb begin
    for (int j = 0; j < 4; j++) pv[j] = cmd.axis ? buf_r[j] : p_r[j];
    tc    = cmd.axis ? u_r : t_r;
    mop   = (cmd.op == DP_CM1) ? c_r : acc_r;
    mop_x = PROD_W'(mop);
    tc_x  = $signed({{(PROD_W-TC_W){1'b0}}, tc});
    prod  = mop_x * tc_x;
    r16   = (m_r + HALF16) >>> FRAC_BITS;
    r17   = (m_r + HALF17) >>> (FRAC_BITS + 1);
    fin   = pv[1] + r17[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      gpend_r <= 1'b0;
    end else begin
      if (cmd.op == DP_OUT) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      pend_r  <= issue;
      gpend_r <= (cmd.op == DP_GRD);
    end
    if (gpend_r) p_r[pj_r] <= VAL_W'($signed(grd_r));
    case (cmd.op)
      DP_ACCEPT: begin
        qx_r <= query_x;
        qy_r <= query_y;
        xi_r <= '0;
        yi_r <= '0;
        k_r  <= CNT_W'(1);
        gi_r <= '0;
        gj_r <= '0;
      end
      DP_SRCH: begin
        if (issue) begin
          k_r  <= k_r + CNT_W'(1);
          pk_r <= k_r;
        end
        if (pend_r && kd <= q_sel) begin
          if (cmd.axis) yi_r <= ROW_W'(pk_r);
          else xi_r <= COL_W'(pk_r);
        end
      end
      DP_RK1: k0_r <= kd;
      DP_DIV_GO: begin
        num_neg_r  <= num_s[NUM_W-1];
        den_neg_r  <= dk[DATA_W];
        den_zero_r <= (dk == '0);
      end
      DP_TSET: begin
        if (cmd.axis) u_r <= tq;
        else t_r <= tq;
        k_r <= CNT_W'(1);
      end
      DP_GRD: begin
        pj_r <= gj_r;
        gj_r <= gj_r + 2'd1;
      end
      DP_CABC: begin
        a_r <= pv[2] - pv[0];
        b_r <= (pv[0] <<< 1) - (pv[1] <<< 2) - pv[1] + (pv[2] <<< 2) - pv[3];
        c_r <= ((pv[1] - pv[2]) <<< 1) + (pv[1] - pv[2]) + pv[3] - pv[0];
      end
      DP_CM1, DP_CM2, DP_CM3: m_r <= prod;
      DP_CS: acc_r <= b_r + r16[VAL_W-1:0];
      DP_CR: acc_r <= a_r + r16[VAL_W-1:0];
      DP_CF: begin
        if (cmd.axis) begin
          if (fin > SAT_HI) begin
            res_r  <= SAT_HI[DATA_W-1:0];
            rsat_r <= 1'b1;
          end else if (fin < SAT_LO) begin
            res_r  <= SAT_LO[DATA_W-1:0];
            rsat_r <= 1'b1;
          end else begin
            res_r  <= fin[DATA_W-1:0];
            rsat_r <= 1'b0;
          end
        end else begin
          buf_r[gi_r] <= fin;
          gi_r        <= gi_r + 2'd1;
        end
      end
      DP_OUT: begin
        ovl_r  <= res_r;
        osat_r <= rsat_r;
      end
      default: ;
    endcase
  end

  assign sts.srch_done = !(k_r <= lim) && !pend_r;
  assign sts.div_busy  = div_busy;
  assign sts.gj_last   = (gj_r == 2'd3);
  assign sts.row_last  = (gi_r == 2'd3);
  assign sts.out_free  = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_value  = ovl_r;
  assign out_sat    = osat_r;
endmodule

/* design/bgi_ctrl.sv */
// controller: sequences search, normalization, gather and cubic steps of a query
// depends on bgi_pkg and the assertion macro header
`include "bicubic_grid_interpolator_macros.svh"
module bgi_ctrl import bgi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    is_query,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_RK0, S_RK1, S_DGO, S_DWAIT, S_GRD, S_GWAIT,
    S_CABC, S_CM1, S_CS, S_CM2, S_CR, S_CM3, S_CF, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   ax_r, ax_nxt;

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    cmd.op    = DP_NOP;
    cmd.axis  = ax_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = DP_ACCEPT;
          if (is_query) begin
            ax_nxt    = 1'b0;
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        cmd.op = DP_SRCH;
        if (sts.srch_done) state_nxt = S_RK0;
      end
      S_RK0: begin
        cmd.op    = DP_RK0;
        state_nxt = S_RK1;
      end
      S_RK1: begin
        cmd.op    = DP_RK1;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        cmd.op    = DP_DIV_GO;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts.div_busy) begin
          cmd.op = DP_TSET;
          if (!ax_r) begin
            ax_nxt    = 1'b1;
            state_nxt = S_SRCH;
          end else begin
            ax_nxt    = 1'b0;
            state_nxt = S_GRD;
          end
        end
      end
      S_GRD: begin
        cmd.op = DP_GRD;
        if (sts.gj_last) state_nxt = S_GWAIT;
      end
      S_GWAIT: state_nxt = S_CABC;
      S_CABC: begin
        cmd.op    = DP_CABC;
        state_nxt = S_CM1;
      end
      S_CM1: begin
        cmd.op    = DP_CM1;
        state_nxt = S_CS;
      end
      S_CS: begin
        cmd.op    = DP_CS;
        state_nxt = S_CM2;
      end
      S_CM2: begin
        cmd.op    = DP_CM2;
        state_nxt = S_CR;
      end
      S_CR: begin
        cmd.op    = DP_CR;
        state_nxt = S_CM3;
      end
      S_CM3: begin
        cmd.op    = DP_CM3;
        state_nxt = S_CF;
      end
      S_CF: begin
        cmd.op = DP_CF;
        if (ax_r) state_nxt = S_OUT;
        else if (sts.row_last) begin
          ax_nxt    = 1'b1;
          state_nxt = S_CABC;
        end else state_nxt = S_GRD;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ax_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
    end
  end

  `BGI_ASSERT(a_query_starts, (state_r == S_IDLE && in_tvalid && is_query) |=> (state_r == S_SRCH), "query request did not start a search")
  `BGI_ASSERT(a_div_next, (state_r == S_DWAIT && !sts.div_busy) |=> (state_r == S_SRCH || state_r == S_GRD), "bad step after division")
  `BGI_ASSERT(a_out_done, (state_r == S_OUT && sts.out_free) |=> (state_r == S_IDLE), "result not handed off")
  `BGI_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> (state_r == S_IDLE), "reset did not return to idle")
endmodule

/* design/bicubic_grid_interpolator.sv */
// bicubic grid interpolator: stores knots and a grid, answers Catmull-Rom queries
// input request stream (in_*), result stream (out_*), register port (cfg_*)
// loads are written in the cycle they are accepted and give no result.
// a query gives one result: interpolated value in out_tdata, saturated flag
// in out_tuser. a query searches each axis over the knot memories (one knot
// read per cycle), runs two serial divisions for the normalized positions,
// then four row cubics, each after four grid memory reads, and one column
// cubic, every cubic with three passes through one shared multiplier.
// one item is worked at a time; in_tready is high only between queries.
// the result waits in an output register; a stalled receiver holds it and a
// load may still be accepted, but the next query finishes only after the
// held result is taken.
// reset idles the controller and sets both counts to 64; knot and grid
// memories are not cleared and must be loaded before they are read.
// registers: 0x0 columns_in_use, 0x4 rows_in_use (7 bits each).
module bicubic_grid_interpolator import bgi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // column_index[5:0], row_index[11:6], load_value[43:12], query_x[75:44],
  // query_y[107:76], zero pad
  input  logic [111:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // interpolated_value[31:0]
  output logic [31:0]  out_tdata,
  // saturated[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [CNT_W-1:0] cols_r, rows_r;
  logic [CNT_W-1:0] n_cols, n_rows;
  logic             wr;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  opcode_t          opcode;
  logic signed [DATA_W-1:0] out_value;
  logic             out_sat;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CNT_W'(MAX_COLUMNS);
      rows_r <= CNT_W'(MAX_ROWS);
    end else if (wr) begin
      if (cfg_paddr[2] == REG_COLS) cols_r <= cfg_pwdata[CNT_W-1:0];
      else rows_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_prdata = {{(32-CNT_W){1'b0}}, (cfg_paddr[2] == REG_ROWS) ? rows_r : cols_r};

  // counts outside the legal range are pulled to it
  always_comb begin
    if (cols_r < CNT_W'(2)) n_cols = CNT_W'(2);
    else if (cols_r > CNT_W'(MAX_COLUMNS)) n_cols = CNT_W'(MAX_COLUMNS);
    else n_cols = cols_r;
    if (rows_r < CNT_W'(2)) n_rows = CNT_W'(2);
    else if (rows_r > CNT_W'(MAX_ROWS)) n_rows = CNT_W'(MAX_ROWS);
    else n_rows = rows_r;
  end

  assign opcode = opcode_t'(in_tuser);

  bgi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .is_query  (opcode == OP_QUERY),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bgi_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .column_index (in_tdata[5:0]),
    .row_index    (in_tdata[11:6]),
    .load_value   (in_tdata[43:12]),
    .query_x      (in_tdata[75:44]),
    .query_y      (in_tdata[107:76]),
    .n_cols       (n_cols),
    .n_rows       (n_rows),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_value    (out_value),
    .out_sat      (out_sat)
  );

  assign out_tdata    = out_value;
  assign out_tuser[0] = out_sat;
endmodule
